/* hw/rtl/four_channel_proximity_qualifier_top_assert.svh */
// Assertion macros shared by the proximity qualifier RTL.
// Needs signals clk and arst_n in the scope of each use.
`ifndef FOUR_CHANNEL_PROXIMITY_QUALIFIER_TOP_ASSERT_SVH
`define FOUR_CHANNEL_PROXIMITY_QUALIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define FCPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcpq assertion failed");

// next-cycle implication
`define FCPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcpq assertion failed");

`endif

/* hw/rtl/fcpq_pkg.sv */
// Shared constants, types and register codes of the proximity qualifier.
// No dependencies.
package fcpq_pkg;
	localparam int WINDOW   = 20;
	localparam int CHANNELS = 4;
	localparam int SAMPLE_W = 12;
	localparam int TIME_W   = 32;
	localparam int DWELL_W  = 16;
	localparam int CFG_W    = DWELL_W;
	localparam int SUM_W    = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
	localparam int IN_W     = CHANNELS * SAMPLE_W + TIME_W;
	localparam int RES_W    = CHANNELS * SAMPLE_W + 2 * CHANNELS + 1;
	localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

	// exact floor divide by window as multiply and shift over the full sum range
	localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam int CLOSE_CH = 2;
	localparam int FORCE_LO = 1;
	localparam int FORCE_HI = 2;

	localparam logic [SAMPLE_W-1:0] ON_RESET    = SAMPLE_W'(1300);
	localparam logic [SAMPLE_W-1:0] OFF_RESET   = SAMPLE_W'(850);
	localparam logic [SAMPLE_W-1:0] CLOSE_RESET = SAMPLE_W'(3000);
	localparam logic [DWELL_W-1:0]  DWELL_RESET = DWELL_W'(10);

	typedef enum logic [1:0] {
		CFG_ON    = 2'd0,
		CFG_OFF   = 2'd1,
		CFG_CLOSE = 2'd2,
		CFG_DWELL = 2'd3
	} cfg_idx_t;

	typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] tap_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] on_th;
		logic [SAMPLE_W-1:0] off_th;
		logic [SAMPLE_W-1:0] close_lvl;
		logic [DWELL_W-1:0]  dwell;
	} cfg_t;

	typedef struct packed {
		tap_t              average;
		logic [TIME_W-1:0] now;
	} avg_t;

	typedef struct packed {
		logic                ovr;
		logic [CHANNELS-1:0] qual;
		logic [CHANNELS-1:0] raw;
		tap_t                average;
	} res_t;
endpackage

/* hw/rtl/fcpq_cell.sv */
// One tap of the sample window: holds one sample per channel.
// Depends on fcpq_pkg.
module fcpq_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  fcpq_pkg::tap_t d,
	output fcpq_pkg::tap_t q
);
	import fcpq_pkg::*;

	tap_t tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;
endmodule

/* hw/rtl/fcpq_window.sv */
// Moving average: chain of sample taps, running sums and the divide by window.
// Depends on fcpq_pkg and fcpq_cell.
module fcpq_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  fcpq_pkg::tap_t              in_samples,
	input  logic [fcpq_pkg::TIME_W-1:0] in_now,
	input  logic                        down_ready,
	output logic                        avg_valid,
	output fcpq_pkg::avg_t              avg_item
);
	import fcpq_pkg::*;

	tap_t              chain [WINDOW];
	logic [SUM_W-1:0]  sum_q [CHANNELS];
	logic [PROD_W-1:0] prod [CHANNELS];
	logic [TIME_W-1:0] now_s1;
	logic              v1_q;
	logic              v2_q;
	avg_t              avg_s2;
	tap_t              avg_d;
	logic              adv1;
	logic              adv2;
	logic              accept;

	assign adv2     = !v2_q || down_ready;
	assign adv1     = !v1_q || adv2;
	assign in_ready = adv1;
	assign accept   = in_valid && adv1;

	for (genvar k = 0; k < WINDOW; k++) begin : g_chain
		if (k == 0) begin : g_head
			fcpq_cell u_tap (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (accept),
				.d     (in_samples),
				.q     (chain[k])
			);
		end else begin : g_body
			fcpq_cell u_tap (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (accept),
				.d     (chain[k-1]),
				.q     (chain[k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c] <= '0;
			end
		end else if (accept) begin
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c] <= sum_q[c] + SUM_W'(in_samples[c]) - SUM_W'(chain[WINDOW-1][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_s1 <= in_now;
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			prod[c]  = PROD_W'(sum_q[c]) * PROD_W'(RECIP_MUL);
			avg_d[c] = prod[c][RECIP_SHIFT +: SAMPLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= in_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v1_q) begin
			avg_s2.average <= avg_d;
			avg_s2.now     <= now_s1;
		end
	end

	assign avg_valid = v2_q;
	assign avg_item  = avg_s2;
endmodule

/* hw/rtl/fcpq_decide.sv */
// Hysteresis, close-range override, dwell qualification and result register.
// Depends on fcpq_pkg and the assertion macro header.
`include "four_channel_proximity_qualifier_top_assert.svh"

module fcpq_decide (
	input  logic           clk,
	input  logic           arst_n,
	input  fcpq_pkg::cfg_t cfg,
	input  logic           avg_valid,
	input  fcpq_pkg::avg_t avg_item,
	output logic           down_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output fcpq_pkg::res_t out_item
);
	import fcpq_pkg::*;

	logic [CHANNELS-1:0] raw_q;
	logic [CHANNELS-1:0] raw_n;
	logic [CHANNELS-1:0] qual_q;
	logic [CHANNELS-1:0] qual_n;
	logic                ovr_q;
	logic                ovr_n;
	logic [TIME_W-1:0]   rise_q [CHANNELS];
	logic [TIME_W-1:0]   rise_n [CHANNELS];
	logic [TIME_W-1:0]   fall_q [CHANNELS];
	logic [TIME_W-1:0]   fall_n [CHANNELS];
	logic                out_valid_q;
	res_t                res_q;
	logic                take;
	logic [TIME_W-1:0]   now;

	assign down_ready = !out_valid_q || out_ready;
	assign take       = avg_valid && down_ready;
	assign now        = avg_item.now;

	always_comb begin
		raw_n  = raw_q;
		rise_n = rise_q;
		fall_n = fall_q;
		qual_n = qual_q;
		ovr_n  = ovr_q;
		for (int c = 0; c < CHANNELS; c++) begin
			if (avg_item.average[c] > cfg.on_th) begin
				if (!raw_n[c]) begin
					rise_n[c] = now;
				end
				raw_n[c] = 1'b1;
			end else if (avg_item.average[c] < cfg.off_th) begin
				if (raw_n[c]) begin
					fall_n[c] = now;
				end
				raw_n[c] = 1'b0;
			end
		end
		if (raw_n == '0) begin
			ovr_n = 1'b0;
		end else if (avg_item.average[CLOSE_CH] > cfg.close_lvl || ovr_q) begin
			if (!raw_n[FORCE_LO]) begin
				rise_n[FORCE_LO] = now;
			end
			if (!raw_n[FORCE_HI]) begin
				rise_n[FORCE_HI] = now;
			end
			raw_n[FORCE_LO] = 1'b1;
			raw_n[FORCE_HI] = 1'b1;
			ovr_n = 1'b1;
		end
		for (int c = 0; c < CHANNELS; c++) begin
			if (raw_n[c]) begin
				if (TIME_W'(now - rise_n[c]) > TIME_W'(cfg.dwell)) begin
					qual_n[c] = 1'b1;
				end
			end else if (TIME_W'(now - fall_n[c]) > TIME_W'(cfg.dwell)) begin
				qual_n[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q  <= '0;
			qual_q <= '0;
			ovr_q  <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				rise_q[c] <= '0;
				fall_q[c] <= '0;
			end
		end else if (take) begin
			raw_q  <= raw_n;
			qual_q <= qual_n;
			ovr_q  <= ovr_n;
			rise_q <= rise_n;
			fall_q <= fall_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (down_ready) begin
			out_valid_q <= avg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.average <= avg_item.average;
			res_q.raw     <= raw_n;
			res_q.qual    <= qual_n;
			res_q.ovr     <= ovr_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = res_q;

	`FCPQ_ASSERT_NOW(a_ovr_forces, ovr_q, raw_q[FORCE_LO] && raw_q[FORCE_HI])
	`FCPQ_ASSERT_NEXT(a_state_holds, !take, $stable(raw_q) && $stable(qual_q) && $stable(ovr_q))
	`FCPQ_ASSERT_NEXT(a_take_shows, take, out_valid_q && res_q.raw == raw_q)
endmodule

/* hw/rtl/four_channel_proximity_qualifier_top.sv */
// Top level of the four-channel proximity qualifier: ports, config registers, packing.
// Depends on fcpq_pkg, fcpq_window, fcpq_decide.
//
//   port group | direction | payload
//   s_*        | in        | four samples and millisecond time
//   m_*        | out       | averages, raw and qualified masks, override flag
//   cfg_*      | in        | threshold, close level and dwell writes
//
// One request per cycle unless m_tready stalls; each result passes v1_q, v2_q, then out_valid_q.
// The window is a shift chain of taps; running sums and detection state update once per request.
// arst_n clears taps, sums, detection state and loads register defaults.
// A stalled m_tready backs up through three stages before s_tready drops.
module four_channel_proximity_qualifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sample_a, sample_b, sample_c, sample_d, now_ms
	input  logic [fcpq_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// average_a, average_b, average_c, average_d, raw_mask, qualified_mask,
	// override_active, zero fill
	output logic [fcpq_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [fcpq_pkg::CFG_W-1:0]    cfg_data
);
	import fcpq_pkg::*;

	cfg_t              cfg_q;
	tap_t              in_samples;
	logic [TIME_W-1:0] in_now;
	logic              avg_valid;
	avg_t              avg_item;
	logic              down_ready;
	res_t              res;

	assign in_samples = s_tdata[CHANNELS*SAMPLE_W-1:0];
	assign in_now     = s_tdata[IN_W-1:CHANNELS*SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_th     <= ON_RESET;
			cfg_q.off_th    <= OFF_RESET;
			cfg_q.close_lvl <= CLOSE_RESET;
			cfg_q.dwell     <= DWELL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ON:    cfg_q.on_th     <= cfg_data[SAMPLE_W-1:0];
				CFG_OFF:   cfg_q.off_th    <= cfg_data[SAMPLE_W-1:0];
				CFG_CLOSE: cfg_q.close_lvl <= cfg_data[SAMPLE_W-1:0];
				CFG_DWELL: cfg_q.dwell     <= cfg_data[DWELL_W-1:0];
				default:   cfg_q           <= cfg_q;
			endcase
		end
	end

	fcpq_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_samples(in_samples),
		.in_now    (in_now),
		.down_ready(down_ready),
		.avg_valid (avg_valid),
		.avg_item  (avg_item)
	);

	fcpq_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.avg_valid (avg_valid),
		.avg_item  (avg_item),
		.down_ready(down_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (res)
	);

	assign m_tdata = {{(OUT_W-RES_W){1'b0}}, res};
endmodule

/* tb/sv/tb_four_channel_proximity_qualifier_top.sv */
// Self-checking testbench of the four-channel proximity qualifier top level.
// Drives samples against its own windowed average, hysteresis, override and dwell model.
// Depends on fcpq_pkg and four_channel_proximity_qualifier_top.
module tb_four_channel_proximity_qualifier_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fcpq_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [SAMPLE_W-1:0] c;
		logic [SAMPLE_W-1:0] d;
		logic [TIME_W-1:0]   now;
		logic                pinned;
		res_t                r;
	} stim_row_t;

	typedef struct packed {
		logic pinned;
		res_t r;
	} pin_t;

	localparam res_t AVG_204 = {1'b0, 4'h0, 4'h0, {4{12'd204}}};
	localparam int DIRECTED_N = 23;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 215;
	localparam int STALL_AT = 400;
	localparam int STALL_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam stim_row_t DIRECTED [0:DIRECTED_N-1] = '{
		'{12'h000, 12'h000, 12'h000, 12'h000, 32'd0, 1'b1, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'hffffffff, 1'b1, AVG_204},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd2, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd4, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd6, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd8, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd10, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd12, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd14, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd16, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd18, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd20, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd22, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd24, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd26, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd28, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd30, 1'b0, '0},
		'{12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'd5, 1'b0, '0},
		'{12'h000, 12'hfff, 12'h000, 12'hfff, 32'd7, 1'b0, '0},
		'{12'haaa, 12'h555, 12'haaa, 12'h555, 32'd8, 1'b0, '0},
		'{12'h555, 12'haaa, 12'h555, 12'haaa, 32'd9, 1'b0, '0},
		'{12'h800, 12'h400, 12'h200, 12'h100, 32'h80000000, 1'b0, '0},
		'{12'h001, 12'h002, 12'h004, 12'h008, 32'h7fffffff, 1'b0, '0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = CFG_ON;
	logic [CFG_W-1:0]    cfg_data = '0;

	logic [SAMPLE_W-1:0] on_th = ON_RESET;
	logic [SAMPLE_W-1:0] off_th = OFF_RESET;
	logic [SAMPLE_W-1:0] close_lvl = CLOSE_RESET;
	logic [DWELL_W-1:0]  dwell = DWELL_RESET;

	logic [SAMPLE_W-1:0] ring [CHANNELS][WINDOW] = '{default: '0};
	int                  ring_slot = 0;
	logic [SUM_W-1:0]    sums [CHANNELS] = '{default: '0};
	logic [CHANNELS-1:0] raw_now = '0;
	logic [TIME_W-1:0]   rise_at [CHANNELS] = '{default: '0};
	logic [TIME_W-1:0]   fall_at [CHANNELS] = '{default: '0};
	logic [CHANNELS-1:0] qual_now = '0;
	logic                ovr_latch = 1'b0;

	res_t expected_readings [$];
	pin_t pinned_results [$];
	int   errors = 0;
	int   results_seen = 0;
	int   idle_cycles = 0;
	bit   no_gaps = 1'b0;
	bit   held_off = 1'b0;

	four_channel_proximity_qualifier_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void raise_channel(input int ch, input logic [TIME_W-1:0] now);
		if (!raw_now[ch]) begin
			rise_at[ch] = now;
		end
		raw_now[ch] = 1'b1;
	endfunction

	function automatic res_t qualify_request(input logic [IN_W-1:0] req);
		logic [TIME_W-1:0]   now;
		logic [SAMPLE_W-1:0] s;
		logic [SAMPLE_W-1:0] avg [CHANNELS];
		logic [TIME_W-1:0]   elapsed;
		res_t                r;
		now = req[CHANNELS*SAMPLE_W +: TIME_W];
		for (int ch = 0; ch < CHANNELS; ch++) begin
			s = req[ch*SAMPLE_W +: SAMPLE_W];
			sums[ch] = sums[ch] + SUM_W'(s) - SUM_W'(ring[ch][ring_slot]);
			ring[ch][ring_slot] = s;
			avg[ch] = SAMPLE_W'(sums[ch] / SUM_W'(WINDOW));
		end
		ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;

		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (avg[ch] > on_th) begin
				raise_channel(ch, now);
			end else if (avg[ch] < off_th) begin
				if (raw_now[ch]) begin
					fall_at[ch] = now;
				end
				raw_now[ch] = 1'b0;
			end
		end

		if (raw_now == '0) begin
			ovr_latch = 1'b0;
		end else if (avg[CLOSE_CH] > close_lvl || ovr_latch) begin
			raise_channel(FORCE_LO, now);
			raise_channel(FORCE_HI, now);
			ovr_latch = 1'b1;
		end

		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (raw_now[ch]) begin
				elapsed = now - rise_at[ch];
				if (elapsed > TIME_W'(dwell)) begin
					qual_now[ch] = 1'b1;
				end
			end else begin
				elapsed = now - fall_at[ch];
				if (elapsed > TIME_W'(dwell)) begin
					qual_now[ch] = 1'b0;
				end
			end
		end

		for (int ch = 0; ch < CHANNELS; ch++) begin
			r.average[ch] = avg[ch];
		end
		r.raw = raw_now;
		r.qual = qual_now;
		r.ovr = ovr_latch;
		return r;
	endfunction

	function automatic void flag_mismatch(input string what, input longint want,
			input longint got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endfunction

	always @(posedge clk) begin
		res_t got;
		res_t want;
		pin_t pin;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pin = pinned_results.pop_front();
				want = qualify_request(s_tdata);
				expected_readings.push_back(pin.pinned ? pin.r : want);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = res_t'(m_tdata[RES_W-1:0]);
				if (expected_readings.size() == 0) begin
					flag_mismatch("unrequested result", 0, longint'(m_tdata));
				end else begin
					want = expected_readings.pop_front();
					for (int ch = 0; ch < CHANNELS; ch++) begin
						if (got.average[ch] !== want.average[ch]) begin
							flag_mismatch($sformatf("average ch%0d", ch), want.average[ch],
								got.average[ch]);
						end
					end
					if (got.raw !== want.raw) begin
						flag_mismatch("raw_mask", want.raw, got.raw);
					end
					if (got.qual !== want.qual) begin
						flag_mismatch("qualified_mask", want.qual, got.qual);
					end
					if (got.ovr !== want.ovr) begin
						flag_mismatch("override_active", want.ovr, got.ovr);
					end
					if (m_tdata[OUT_W-1:RES_W] !== '0) begin
						flag_mismatch("zero fill", 0, m_tdata[OUT_W-1:RES_W]);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= STALL_AT) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end
			m_tready <= no_gaps || $urandom_range(99) >= 16;
		end
	end

	task automatic offer_request(input logic [IN_W-1:0] req, input logic pinned,
			input res_t r);
		while (!no_gaps && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		pinned_results.push_back('{pinned, r});
		s_tvalid <= 1'b1;
		s_tdata <= req;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_ON:    on_th = val[SAMPLE_W-1:0];
			CFG_OFF:   off_th = val[SAMPLE_W-1:0];
			CFG_CLOSE: close_lvl = val[SAMPLE_W-1:0];
			CFG_DWELL: dwell = val;
		endcase
	endtask

	function automatic int pick_level();
		case ($urandom_range(5))
			0: return 0;
			1: return 4095;
			2: return int'($urandom_range(4095));
			3: return int'(on_th) + int'($urandom_range(200)) - 100;
			4: return int'(off_th) + int'($urandom_range(200)) - 100;
			default: return int'(close_lvl) + int'($urandom_range(200)) - 100;
		endcase
	endfunction

	initial begin
		int                  levels [CHANNELS];
		int                  v;
		logic [IN_W-1:0]     req;
		logic [TIME_W-1:0]   now_ms;
		logic [SAMPLE_W-1:0] on_v;
		logic [SAMPLE_W-1:0] off_v;
		logic [SAMPLE_W-1:0] close_v;
		logic [DWELL_W-1:0]  dwell_v;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++) begin
			offer_request({DIRECTED[i].now, DIRECTED[i].d, DIRECTED[i].c, DIRECTED[i].b,
				DIRECTED[i].a}, DIRECTED[i].pinned, DIRECTED[i].r);
		end

		now_ms = 32'd100;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			levels[ch] = pick_level();
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (expected_readings.size() != 0) @(posedge clk);
			if (phase > 0) begin
				case (phase)
					1: begin
						on_v = '0;
						off_v = '0;
						close_v = '0;
						dwell_v = '0;
					end
					2: begin
						on_v = '1;
						off_v = '1;
						close_v = '1;
						dwell_v = '1;
					end
					3: begin
						off_v = SAMPLE_W'($urandom_range(4095, 1500));
						on_v = SAMPLE_W'($urandom_range(off_v - 1));
						close_v = SAMPLE_W'($urandom_range(4095));
						dwell_v = DWELL_W'($urandom_range(30));
					end
					default: begin
						on_v = SAMPLE_W'($urandom_range(3500, 600));
						off_v = on_v - SAMPLE_W'($urandom_range(600));
						close_v = SAMPLE_W'($urandom_range(4095));
						dwell_v = DWELL_W'($urandom_range(30));
					end
				endcase
				write_reg(CFG_ON, {4'($urandom_range(15)), on_v});
				write_reg(CFG_OFF, {4'($urandom_range(15)), off_v});
				write_reg(CFG_CLOSE, {4'($urandom_range(15)), close_v});
				write_reg(CFG_DWELL, dwell_v);
				cfg_we <= 1'b0;
			end
			no_gaps = (phase == 2);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					if ($urandom_range(29) == 0) begin
						levels[ch] = pick_level();
					end
					if ($urandom_range(9) == 0) begin
						v = int'($urandom_range(4095));
					end else begin
						v = levels[ch] + int'($urandom_range(200)) - 100;
					end
					if (v < 0) begin
						v = 0;
					end
					if (v > 4095) begin
						v = 4095;
					end
					req[ch*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(v);
				end
				case ($urandom_range(99))
					0, 1: now_ms = $urandom();
					2: now_ms = now_ms - TIME_W'($urandom_range(50));
					default: now_ms = now_ms + TIME_W'($urandom_range(4));
				endcase
				req[CHANNELS*SAMPLE_W +: TIME_W] = now_ms;
				offer_request(req, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		no_gaps = 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
